@@ rtl/core/spf_pkg.sv @@
// Shared types, constants and tables for the segment/polygon first-hit unit.
package spf_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned VtxW   = 26;
  localparam int unsigned DiffW  = 27;
  localparam int unsigned OpW    = 28;
  localparam int unsigned ProdW  = 56;
  localparam int unsigned ParamW = 18;
  localparam int unsigned QW     = 17;
  localparam int unsigned SidesW = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 63;
  localparam int unsigned AngleShift = 6;  // 1/1024 turn to 1/65536 turn

  localparam logic [CfgIdxW-1:0] RegCenterX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRadius  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRotate  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScales  = 3'd4;

  localparam logic [15:0]         RadiusReset = 16'd15360;
  localparam logic [CfgDataW-1:0] ScalesReset = {9{7'd64}};

  localparam logic [15:0] Rad6Min = 16'd3840;
  localparam logic [15:0] Rad7Min = 16'd7680;
  localparam logic [15:0] Rad9Above = 16'd51200;

  localparam logic [ParamW-1:0] NoHitParam = 18'd131072;
  localparam logic [QW-1:0]     OneParam   = 17'd65536;

  localparam logic signed [23:0] SinC0 = 24'sd11;
  localparam logic signed [23:0] SinC1 = -24'sd307;
  localparam logic signed [23:0] SinC2 = 24'sd5223;
  localparam logic signed [23:0] SinC3 = -24'sd42334;
  localparam logic signed [23:0] SinC4 = 24'sd102944;

  typedef logic [15:0] ph_tab_t [9];
  localparam ph_tab_t PhTab5 = '{16'd0, 16'd13107, 16'd26214, 16'd39321, 16'd52428,
                                 16'd0, 16'd0, 16'd0, 16'd0};
  localparam ph_tab_t PhTab6 = '{16'd0, 16'd10922, 16'd21845, 16'd32768, 16'd43690,
                                 16'd54613, 16'd0, 16'd0, 16'd0};
  localparam ph_tab_t PhTab7 = '{16'd0, 16'd9362, 16'd18724, 16'd28086, 16'd37449,
                                 16'd46811, 16'd56173, 16'd0, 16'd0};
  localparam ph_tab_t PhTab8 = '{16'd0, 16'd8192, 16'd16384, 16'd24576, 16'd32768,
                                 16'd40960, 16'd49152, 16'd57344, 16'd0};
  localparam ph_tab_t PhTab9 = '{16'd0, 16'd7281, 16'd14563, 16'd21845, 16'd29127,
                                 16'd36408, 16'd43690, 16'd50972, 16'd58254};

  // floor(idx * 65536 / sides)
  function automatic logic [15:0] vtx_phase(logic [SidesW-1:0] sides, logic [3:0] idx);
    logic [15:0] res;
    res = '0;
    case (sides)
      4'd5: res = PhTab5[idx];
      4'd6: res = PhTab6[idx];
      4'd7: res = PhTab7[idx];
      4'd8: res = PhTab8[idx];
      4'd9: res = PhTab9[idx];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/segment_polygon_first_hit_unit.sv @@
// Top level: first crossing of a segment with a configured radial polygon.
// One beat in, one beat out. The block builds every vertex with a single shared
// 28x28 multiplier (sine polynomial, radius scaling), then runs each edge through
// the same multiplier for its three cross products, and divides each crossing
// edge in a 17-step serial divider. The polygon has 5, 6, 7 or 9 sides, picked from the
// radius and capped at MAX_SIDES; the vertex build through the one multiplier dominates.
// The input side is not ready while an item is in progress.
module segment_polygon_first_hit_unit #(
  parameter int unsigned MAX_SIDES = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [95:0]                  s_axis_tdata,  // start_x, start_y, end_x, end_y
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // hit_param, zero fill
  output logic                         m_axis_tuser   // hit
);

  localparam int unsigned IW = (MAX_SIDES > 1) ? $clog2(MAX_SIDES) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StVtx  = 3'd1;
  localparam logic [2:0] StEdge = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam logic [3:0] V0 = 4'd0,  V1 = 4'd1,  V2 = 4'd2,  V3 = 4'd3;
  localparam logic [3:0] V4 = 4'd4,  V5 = 4'd5,  V6 = 4'd6,  V7 = 4'd7;
  localparam logic [3:0] V8 = 4'd8,  V9 = 4'd9,  V10 = 4'd10, V11 = 4'd11;
  localparam logic [3:0] V12 = 4'd12, V13 = 4'd13, V14 = 4'd14, V15 = 4'd15;
  localparam logic [3:0] E0 = 4'd0,  E1 = 4'd1,  E2 = 4'd2,  E3 = 4'd3;
  localparam logic [3:0] E4 = 4'd4,  E5 = 4'd5,  E6 = 4'd6,  E7 = 4'd7;
  localparam logic [3:0] E8 = 4'd8,  E9 = 4'd9,  E10 = 4'd10, E11 = 4'd11;

  // configuration
  logic signed [23:0]          center_x_q, center_y_q;
  logic [15:0]                 radius_q;
  logic [9:0]                  rot_q;
  logic [spf_pkg::CfgDataW-1:0] scales_q;

  // control
  logic [2:0]                  state_q, state_d;
  logic [3:0]                  step_q, step_d;
  logic [IW-1:0]               vi_q, vi_d;
  logic                        tsel_q, tsel_d;
  logic [spf_pkg::SidesW-1:0]  sides_q, sides_d;
  logic                        hit_q, hit_d;
  logic                        m_valid_q, m_valid_d;

  // datapath
  logic [15:0]                 ph_q, ph_d;
  logic [22:0]                 rs_q, rs_d;
  logic [16:0]                 z_q, z_d;
  logic [16:0]                 z2_q, z2_d;
  logic                        neg_q, neg_d;
  logic signed [23:0]          acc_q, acc_d;
  logic signed [17:0]          trig_q, trig_d;
  logic signed [23:0]          ax_q, ay_q, ax_d, ay_d;
  logic signed [24:0]          dx_q, dy_q, dx_d, dy_d;
  logic signed [spf_pkg::VtxW-1:0]  xi_q, yi_q, xi_d, yi_d;
  logic signed [spf_pkg::DiffW-1:0] ex_q, ey_q, fx_q, fy_q, ex_d, ey_d, fx_d, fy_d;
  logic signed [spf_pkg::ProdW-1:0] den_q, tn_q, un_q, den_d, tn_d, un_d;
  logic [spf_pkg::QW-1:0]      best_q, best_d;
  logic                        m_hit_q, m_hit_d;
  logic [spf_pkg::ParamW-1:0]  m_param_q, m_param_d;

  // shared multiplier
  logic signed [spf_pkg::OpW-1:0]   mul_a, mul_b;
  logic signed [spf_pkg::ProdW-1:0] p_q;

  // vertex store
  logic signed [spf_pkg::VtxW-1:0] vx_mem [MAX_SIDES];
  logic signed [spf_pkg::VtxW-1:0] vy_mem [MAX_SIDES];
  logic signed [spf_pkg::VtxW-1:0] rd_x_q, rd_y_q;
  logic [IW-1:0]                   rd_addr;
  logic                            wr_x, wr_y;
  logic signed [spf_pkg::VtxW-1:0] coord;

  // misc
  logic                        in_acc, last_idx, div_start, div_done;
  logic [spf_pkg::QW-1:0]      div_q;
  logic [IW-1:0]               vj;
  logic [15:0]                 tph;
  logic [13:0]                 tr;
  logic signed [23:0]          psh;
  logic signed [spf_pkg::ProdW-1:0] rnd;
  logic signed [19:0]          off;
  logic [16:0]                 mag;
  logic [spf_pkg::SidesW-1:0]  base_sides;
  logic [6:0]                  scale;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_hit_q;
  assign m_axis_tdata  = {6'd0, m_param_q};

  assign last_idx = ((spf_pkg::SidesW)'(vi_q) == sides_q - 4'd1);
  assign vj       = last_idx ? '0 : vi_q + 1'b1;
  assign tph      = ph_q + (tsel_q ? 16'd0 : 16'd16384);
  assign tr       = tph[13:0];
  assign psh      = $signed(p_q[39:16]);
  assign rnd      = p_q + 56'sd2097152;
  assign off      = $signed(rnd[41:22]);
  assign scale    = scales_q[7*vi_q +: 7];

  always_comb begin
    if (radius_q < spf_pkg::Rad6Min) base_sides = 4'd5;
    else if (radius_q < spf_pkg::Rad7Min) base_sides = 4'd6;
    else if (radius_q > spf_pkg::Rad9Above) base_sides = 4'd9;
    else base_sides = 4'd7;
  end

  always_comb begin
    if (psh < 0) mag = '0;
    else if (psh > 24'sd65536) mag = 17'd65536;
    else mag = psh[16:0];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == StVtx) begin
      case (step_q)
        V0: begin
          mul_a = $signed(28'(radius_q));
          mul_b = $signed(28'(scale));
        end
        V2: begin
          mul_a = $signed(28'(z_q));
          mul_b = $signed(28'(z_q));
        end
        V4, V6, V8, V10: begin
          mul_a = 28'(acc_q);
          mul_b = $signed(28'(z2_q));
        end
        V12: begin
          mul_a = 28'(acc_q);
          mul_b = $signed(28'(z_q));
        end
        V14: begin
          mul_a = $signed(28'(rs_q));
          mul_b = 28'(trig_q);
        end
        default: ;
      endcase
    end else if (state_q == StEdge) begin
      case (step_q)
        E3: begin mul_a = 28'(dx_q); mul_b = 28'(ey_q); end
        E4: begin mul_a = 28'(dy_q); mul_b = 28'(ex_q); end
        E5: begin mul_a = 28'(fx_q); mul_b = 28'(ey_q); end
        E6: begin mul_a = 28'(fy_q); mul_b = 28'(ex_q); end
        E7: begin mul_a = 28'(fx_q); mul_b = 28'(dy_q); end
        E8: begin mul_a = 28'(fy_q); mul_b = 28'(dx_q); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  assign coord = (spf_pkg::VtxW)'(tsel_q ? center_y_q : center_x_q) + (spf_pkg::VtxW)'(off);
  assign wr_x  = (state_q == StVtx) && (step_q == V15) && !tsel_q;
  assign wr_y  = (state_q == StVtx) && (step_q == V15) && tsel_q;
  assign rd_addr = (step_q == E0) ? vi_q : vj;

  always_ff @(posedge clk_i) begin
    if (wr_x) vx_mem[vi_q] <= coord;
    if (wr_y) vy_mem[vi_q] <= coord;
    rd_x_q <= vx_mem[rd_addr];
    rd_y_q <= vy_mem[rd_addr];
  end

  spf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tn_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    state_d = state_q;   step_d = step_q;   vi_d = vi_q;     tsel_d = tsel_q;
    sides_d = sides_q;   hit_d = hit_q;     m_valid_d = m_valid_q;
    ph_d = ph_q;         rs_d = rs_q;       z_d = z_q;       z2_d = z2_q;
    neg_d = neg_q;       acc_d = acc_q;     trig_d = trig_q;
    ax_d = ax_q;         ay_d = ay_q;       dx_d = dx_q;     dy_d = dy_q;
    xi_d = xi_q;         yi_d = yi_q;
    ex_d = ex_q;         ey_d = ey_q;       fx_d = fx_q;     fy_d = fy_q;
    den_d = den_q;       tn_d = tn_q;       un_d = un_q;     best_d = best_q;
    m_hit_d = m_hit_q;   m_param_d = m_param_q;
    div_start = 1'b0;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          ax_d = $signed(s_axis_tdata[23:0]);
          ay_d = $signed(s_axis_tdata[47:24]);
          dx_d = 25'($signed(s_axis_tdata[71:48])) - 25'($signed(s_axis_tdata[23:0]));
          dy_d = 25'($signed(s_axis_tdata[95:72])) - 25'($signed(s_axis_tdata[47:24]));
          sides_d = ({1'b0, base_sides} > 5'(MAX_SIDES)) ? 4'(MAX_SIDES) : base_sides;
          vi_d    = '0;
          step_d  = V0;
          hit_d   = 1'b0;
          best_d  = '0;
          state_d = StVtx;
        end
      end
      StVtx: begin
        step_d = step_q + 4'd1;
        case (step_q)
          V0: begin
            ph_d   = {rot_q, {spf_pkg::AngleShift{1'b0}}} + spf_pkg::vtx_phase(sides_q, 4'(vi_q));
            tsel_d = 1'b0;
          end
          V1: begin
            if (!tsel_q) rs_d = p_q[22:0];
            z_d   = {(tph[14] ? (15'd16384 - {1'b0, tr}) : {1'b0, tr}), 2'b00};
            neg_d = tph[15];
          end
          V3: begin
            z2_d  = p_q[32:16];
            acc_d = spf_pkg::SinC0;
          end
          V5:  acc_d = spf_pkg::SinC1 + psh;
          V7:  acc_d = spf_pkg::SinC2 + psh;
          V9:  acc_d = spf_pkg::SinC3 + psh;
          V11: acc_d = spf_pkg::SinC4 + psh;
          V13: trig_d = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          V15: begin
            if (!tsel_q) begin
              tsel_d = 1'b1;
              step_d = V1;
            end else if (last_idx) begin
              vi_d    = '0;
              step_d  = E0;
              state_d = StEdge;
            end else begin
              vi_d   = vi_q + 1'b1;
              step_d = V0;
            end
          end
          default: ;
        endcase
      end
      StEdge: begin
        step_d = step_q + 4'd1;
        case (step_q)
          E1: begin
            xi_d = rd_x_q;
            yi_d = rd_y_q;
          end
          E2: begin
            ex_d = 27'(rd_x_q) - 27'(xi_q);
            ey_d = 27'(rd_y_q) - 27'(yi_q);
            fx_d = 27'(xi_q) - 27'(ax_q);
            fy_d = 27'(yi_q) - 27'(ay_q);
          end
          E4: den_d = p_q;
          E5: den_d = den_q - p_q;
          E6: tn_d  = p_q;
          E7: tn_d  = tn_q - p_q;
          E8: un_d  = p_q;
          E9: un_d  = un_q - p_q;
          E10: begin
            if (den_q == '0) begin
              step_d = E0;
              if (last_idx) state_d = StOut;
              else vi_d = vi_q + 1'b1;
            end else if (den_q < 0) begin
              den_d = -den_q;
              tn_d  = -tn_q;
              un_d  = -un_q;
            end
          end
          E11: begin
            step_d = E0;
            if (!tn_q[spf_pkg::ProdW-1] && (tn_q <= den_q) &&
                !un_q[spf_pkg::ProdW-1] && (un_q <= den_q)) begin
              div_start = 1'b1;
              state_d   = StDiv;
            end else if (last_idx) begin
              state_d = StOut;
            end else begin
              vi_d = vi_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      StDiv: begin
        if (div_done) begin
          if (!hit_q || (div_q < best_q)) best_d = div_q;
          hit_d = 1'b1;
          if (last_idx) begin
            state_d = StOut;
          end else begin
            vi_d    = vi_q + 1'b1;
            state_d = StEdge;
          end
        end
      end
      StOut: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_hit_d   = hit_q;
          m_param_d = hit_q ? {1'b0, best_q} : spf_pkg::NoHitParam;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      step_q     <= '0;
      vi_q       <= '0;
      tsel_q     <= 1'b0;
      sides_q    <= 4'd5;
      hit_q      <= 1'b0;
      m_valid_q  <= 1'b0;
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= spf_pkg::RadiusReset;
      rot_q      <= '0;
      scales_q   <= spf_pkg::ScalesReset;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      vi_q      <= vi_d;
      tsel_q    <= tsel_d;
      sides_q   <= sides_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spf_pkg::RegCenterX: center_x_q <= $signed(cfg_data_i[23:0]);
          spf_pkg::RegCenterY: center_y_q <= $signed(cfg_data_i[23:0]);
          spf_pkg::RegRadius:  radius_q   <= cfg_data_i[15:0];
          spf_pkg::RegRotate:  rot_q      <= cfg_data_i[9:0];
          spf_pkg::RegScales:  scales_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q <= ph_d;     rs_q <= rs_d;     z_q <= z_d;       z2_q <= z2_d;
    neg_q <= neg_d;   acc_q <= acc_d;   trig_q <= trig_d;
    ax_q <= ax_d;     ay_q <= ay_d;     dx_q <= dx_d;     dy_q <= dy_d;
    xi_q <= xi_d;     yi_q <= yi_d;
    ex_q <= ex_d;     ey_q <= ey_d;     fx_q <= fx_d;     fy_q <= fy_d;
    den_q <= den_d;   tn_q <= tn_d;     un_q <= un_d;     best_q <= best_d;
    m_hit_q <= m_hit_d;
    m_param_q <= m_param_d;
  end

endmodule

@@ rtl/core/spf_div.sv @@
// Bit-serial restoring divider giving the rounded Q1.16 fraction num/den.
module spf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [spf_pkg::ProdW-1:0] num_i,
  input  logic [spf_pkg::ProdW-1:0] den_i,
  output logic                      done_o,
  output logic [spf_pkg::QW-1:0]    q_o
);

  logic                      busy_q, busy_d;
  logic [4:0]                cnt_q, cnt_d;
  logic                      big_q, big_d;
  logic [spf_pkg::ProdW:0]   r_q, r_d;
  logic [15:0]               q_q, q_d;
  logic [spf_pkg::ProdW-1:0] den_q, den_d;
  logic [spf_pkg::ProdW:0]   r2;
  logic                      ge;

  assign r2 = {r_q[spf_pkg::ProdW-1:0], 1'b0};
  assign ge = (r2 >= {1'b0, den_q});
  assign done_o = busy_q && (cnt_q == 5'd16);
  assign q_o = big_q ? spf_pkg::OneParam : ({1'b0, q_q} + {16'd0, ge});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    big_d  = big_q;
    r_d    = r_q;
    q_d    = q_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      big_d  = (num_i >= den_i);
      r_d    = {1'b0, num_i};
      q_d    = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (cnt_q == 5'd16) begin
        busy_d = 1'b0;
      end else begin
        r_d   = ge ? (r2 - {1'b0, den_q}) : r2;
        q_d   = {q_q[14:0], ge};
        cnt_d = cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    big_q <= big_d;
    r_q   <= r_d;
    q_q   <= q_d;
    den_q <= den_d;
  end

endmodule

@@ rtl/core/spf_checker.sv @@
// Port-level checks for the segment/polygon first-hit unit, bound to the top level.
module spf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a beat was taken");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd131072)
    else $error("miss beat without 2.0 parameter");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata <= 24'd65536)
    else $error("hit parameter above 1.0");

endmodule

bind segment_polygon_first_hit_unit spf_checker u_spf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
